>>> sv/fwc_pkg.sv
// Shared types, constants and the byte-step function for the fuse word CRC-8 engine.
// No dependencies.
`default_nettype none

package fwc_pkg;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_TOP  = 8'h80;
	localparam int         BYTE_W   = 8;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	// Fold one byte into the running CRC, MSB first, eight shift steps.
	function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] r;
		r = crc ^ data;
		for (int k = 0; k < BYTE_W; k++) begin
			if ((r & CRC_TOP) != 8'h00) begin
				r = (r << 1) ^ CRC_POLY;
			end else begin
				r = r << 1;
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> sv/fuse_word_crc8_engine_unit.sv
// Top level of the fuse word CRC-8 engine: byte sequencer around one CRC byte unit.
// Depends on fwc_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one fuse word: word_value, its
//   bit_count (saturated to MAX_WORD_BITS) and last_word. Bits above the count
//   are dropped, and the word is cut into ceil(count/8) bytes that enter the
//   CRC most significant byte first.
//   Output channel (out_valid / out_stall) carries crc_value, one per word
//   marked last: CRC-8, polynomial 0x31, init 0, no reflection, no final XOR.
//   The running CRC clears after each report.
// Timing:
//   One byte is folded per cycle by the single CRC byte unit, so a word holds
//   the input stalled while its ceil(count/8) bytes are folded (up to 8 at 64
//   bits). A last word then also holds it in the DONE state, which hands its
//   CRC to the output register and raises out_valid.
//   The output register lets a new word be taken while a CRC waits; a last
//   word whose CRC is ready while the previous one is still stalled waits for it.
// Reset:
//   arst_n clears the sequencer, the running CRC and out_valid at once.
`default_nettype none

module fuse_word_crc8_engine_unit #(
	parameter int MAX_WORD_BITS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] word_value,
	input  wire logic [6:0]  bit_count,
	input  wire logic        last_word,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       crc_value
);

	localparam int NBYTES = (MAX_WORD_BITS + 7) / 8;
	localparam int IDX_W  = (NBYTES > 1) ? $clog2(NBYTES) : 1;
	localparam int CNT_W  = $clog2(NBYTES + 1);
	localparam logic [6:0] MAX_CNT = 7'(MAX_WORD_BITS);

	fwc_pkg::state_t state_q;
	logic [7:0]       bytes_q [NBYTES];
	logic [CNT_W-1:0] cnt_q;
	logic             last_q;
	logic [7:0]       crc_q;
	logic             out_valid_q;
	logic [7:0]       crc_value_q;

	logic [6:0]       cnt_sat;
	logic [63:0]      masked;
	logic [6:0]       nbytes_full;
	logic [CNT_W-1:0] nbytes;
	logic [IDX_W-1:0] idx;
	logic [7:0]       crc_next;
	logic             in_acc;
	logic             out_free;

	assign cnt_sat = (bit_count > MAX_CNT) ? MAX_CNT : bit_count;

	always_comb begin
		for (int i = 0; i < 64; i++) begin
			masked[i] = word_value[i] & (7'(i) < cnt_sat);
		end
	end

	assign nbytes_full = (cnt_sat + 7'd7) >> 3;
	assign nbytes      = nbytes_full[CNT_W-1:0];
	assign idx         = IDX_W'(cnt_q - CNT_W'(1));
	assign crc_next    = fwc_pkg::crc_byte(crc_q, bytes_q[idx]);

	assign in_stall  = (state_q != fwc_pkg::ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign crc_value = crc_value_q;

	// Word bytes: payload only, loaded on accept.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int b = 0; b < NBYTES; b++) begin
				bytes_q[b] <= masked[b*8 +: 8];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fwc_pkg::ST_IDLE;
			cnt_q       <= '0;
			last_q      <= 1'b0;
			crc_q       <= 8'h00;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == fwc_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				fwc_pkg::ST_IDLE: begin
					if (in_acc) begin
						cnt_q  <= nbytes;
						last_q <= last_word;
						if (nbytes != '0) begin
							state_q <= fwc_pkg::ST_RUN;
						end else if (last_word) begin
							state_q <= fwc_pkg::ST_DONE;
						end
					end
				end
				fwc_pkg::ST_RUN: begin
					// Fold the highest remaining byte, advance toward byte 0.
					crc_q <= crc_next;
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= last_q ? fwc_pkg::ST_DONE : fwc_pkg::ST_IDLE;
					end
				end
				fwc_pkg::ST_DONE: begin
					// Hold until the output register is free, then report and clear.
					if (out_free) begin
						crc_q   <= 8'h00;
						state_q <= fwc_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= fwc_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == fwc_pkg::ST_DONE && out_free) begin
			crc_value_q <= crc_q;
		end
	end

	a_run_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fwc_pkg::ST_RUN |-> cnt_q != '0)
		else $error("byte sequencer running with no bytes left");

	a_rise_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == fwc_pkg::ST_DONE))
		else $error("result raised outside the report step");

	a_clear_after_report: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fwc_pkg::ST_DONE && out_free) |=> (crc_q == 8'h00 && out_valid))
		else $error("running CRC not cleared or result not shown after report");

endmodule

`default_nettype wire
